@@ rtl/prt_pkg.sv @@
// Package for the peer recency table: field widths, command codes, item types.
// Used by prt_table, prt_ctrl and peer_recency_table; depends on nothing.
package prt_pkg;

  localparam int ADDR_W  = 48;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [TIME_W-1:0]  WINDOW_RESET  = TIME_W'(5 * 60 * 1000);

  // Command codes carried in the input item
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] station_addr;
    logic [TIME_W-1:0] now_ms;
  } prt_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_written;
    logic [COUNT_W-1:0] live_count;
  } prt_out_t;

  // Write request from the sequencer to the entry store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stamp;
  } prt_wr_t;

endpackage

@@ rtl/prt_table.sv @@
// Entry store of the peer recency table: one write port, one registered read port,
// plus per-entry valid flops so reset empties the table at once. Uses prt_pkg.
module prt_table import prt_pkg::*; #(
  parameter int ENTRIES = 32,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IW-1:0]     raddr,
  output logic [ADDR_W-1:0] rd_addr,
  output logic [TIME_W-1:0] rd_time,
  input  prt_wr_t           wr,
  input  logic [IW-1:0]     widx
);

  logic [ADDR_W+TIME_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]       vld;
  logic [ADDR_W+TIME_W-1:0] rd_q;
  logic                     rd_vld;

  // Write the entry and read one address every cycle
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[widx] <= {wr.addr, wr.stamp};
    end
    rd_q <= mem[raddr];
  end

  // Track which entries have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.we) begin
        vld[widx] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  // An entry never written reads as cleared
  assign rd_addr = rd_vld ? rd_q[ADDR_W+TIME_W-1:TIME_W] : '0;
  assign rd_time = rd_vld ? rd_q[TIME_W-1:0] : '0;

endmodule

@@ rtl/prt_ctrl.sv @@
// Scan sequencer of the peer recency table: walks the entries one per cycle
// through a single shared 32-bit less-than unit. Uses prt_pkg; drives prt_table.
module prt_ctrl import prt_pkg::*; #(
  parameter int ENTRIES = 32,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  prt_in_t           item,
  input  logic [TIME_W-1:0] window,
  output logic              done,
  output prt_out_t          result,
  output logic [IW-1:0]     raddr,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [TIME_W-1:0] rd_time,
  output prt_wr_t           wr,
  output logic [IW-1:0]     widx
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_SCAN, S_WRITE} state_t;

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t             state;
  prt_in_t            item_q;
  logic [IW-1:0]      ridx;
  logic [IW-1:0]      cidx;
  logic [IW-1:0]      slot;
  logic [IW-1:0]      oldest_idx;
  logic [TIME_W-1:0]  oldest_time;
  logic [COUNT_W-1:0] count;

  logic              accept;
  logic              last;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] cmp_a;
  logic [TIME_W-1:0] cmp_b;
  logic              lt;
  logic              stop;
  logic              take;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign raddr  = ridx;
  assign last   = (cidx == LAST);

  // Shared compare unit: age against window for query, time against oldest for record
  assign age   = item_q.now_ms - rd_time;
  assign cmp_a = (item_q.cmd == CMD_QUERY) ? age : rd_time;
  assign cmp_b = (item_q.cmd == CMD_QUERY) ? window : oldest_time;
  assign lt    = (cmp_a < cmp_b);

  // Record: stop on a matching address or an empty entry; track the oldest
  assign stop = (rd_addr == item_q.station_addr) || (rd_time == '0);
  assign take = (cidx == '0) || lt;

  assign wr.we    = (state == S_WRITE);
  assign wr.addr  = item_q.station_addr;
  assign wr.stamp = item_q.now_ms;
  assign widx     = slot;

  // Sequencer state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      result <= '0;
      ridx   <= '0;
      cidx   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_q <= item;
            ridx   <= '0;
            cidx   <= '0;
            count  <= '0;
            state  <= S_FETCH;
          end
        end
        S_FETCH: begin
          // First read is in flight; advance the read pointer
          ridx  <= (ridx == LAST) ? ridx : ridx + IW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          ridx <= (ridx == LAST) ? ridx : ridx + IW'(1);
          cidx <= cidx + IW'(last ? 0 : 1);
          if (item_q.cmd == CMD_QUERY) begin
            if ((rd_time != '0) && lt && (count != COUNT_MAX)) begin
              count <= count + COUNT_W'(1);
            end
            if (last) begin
              result.slot_written <= '0;
              result.live_count   <= ((rd_time != '0) && lt && (count != COUNT_MAX)) ?
                                     count + COUNT_W'(1) : count;
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            if (stop) begin
              slot  <= cidx;
              state <= S_WRITE;
            end else begin
              if (take) begin
                oldest_idx  <= cidx;
                oldest_time <= rd_time;
              end
              if (last) begin
                slot  <= take ? cidx : oldest_idx;
                state <= S_WRITE;
              end
            end
          end
        end
        S_WRITE: begin
          result.slot_written <= SLOT_W'(slot);
          result.live_count   <= '0;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result strobe comes only once the sequencer is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted item always makes the sequencer busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start a scan");

  // A table write is followed by the record result
  a_write_done: assert property (@(posedge clk) disable iff (rst) wr.we |=> done)
    else $error("table write without result");

  // A record result carries no live count
  a_record_count: assert property (@(posedge clk) disable iff (rst)
    (done && (item_q.cmd == CMD_RECORD)) |-> (result.live_count == '0))
    else $error("record result with nonzero live count");

endmodule

@@ rtl/peer_recency_table.sv @@
// Peer recency table: station address table with last-seen times.
// Channels: an item is taken on a clock edge with start high and busy low.
//   item.cmd = record (0) writes item.station_addr / item.now_ms into the
//   first matching or empty entry, else into the oldest entry (lowest index
//   on a tie); query (1) counts entries with nonzero time whose wrapped age
//   now_ms - time is below the stale window.
// Each item gives exactly one result, shown on result for one cycle with done
//   high; there is no back-pressure, so the receiver must take it then.
// Busy: a record keeps busy high through a fetch, a scan of entries 0 up to
//   the entry k where it stops, and a table write; a query through a fetch
//   and a scan of every entry. done pulses in the cycle busy falls, and a new
//   item may be started in that same cycle. The scan goes one entry per cycle
//   over the entry store's single read port; a record with no match is worst.
// Configuration: cfg_we with cfg_wdata sets the stale window (reset 300000 ms);
//   write it only while busy is low.
// Reset (rst, synchronous) empties the table at once and restores the window.
// Depends on prt_pkg, prt_table and prt_ctrl.
module peer_recency_table import prt_pkg::*; #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  prt_in_t           item,
  output logic              done,
  output prt_out_t          result,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TIME_W-1:0] window;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     widx;
  logic [ADDR_W-1:0] rd_addr;
  logic [TIME_W-1:0] rd_time;
  prt_wr_t           wr;

  // Hold the stale window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_wdata;
    end
  end

  prt_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .rst     (rst),
    .raddr   (raddr),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .wr      (wr),
    .widx    (widx)
  );

  prt_ctrl #(.ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .window  (window),
    .done    (done),
    .result  (result),
    .raddr   (raddr),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .wr      (wr),
    .widx    (widx)
  );

endmodule
